// ===== rtl/pen_line_rasterizer_macros.svh =====
// ----------------------------------------------------------------------------
// Pen line rasterizer assertion macros
// Shorthand for the clocked properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PEN_LINE_RASTERIZER_MACROS_SVH
`define PEN_LINE_RASTERIZER_MACROS_SVH

// same-cycle implication, off while reset is high
`define PLR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("plr: property failed");

// next-cycle implication, off while reset is high
`define PLR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("plr: property failed");

// next-cycle implication, always checked (used for reset behavior)
`define PLR_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("plr: property failed");

`endif

// ===== rtl/plr_pkg.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer package
// Shared constants, register indexes, controller state and command types.
// ----------------------------------------------------------------------------
`default_nettype none

package plr_pkg;

   localparam int unsigned COORD_BITS_DEF   = 13;
   localparam int unsigned PEN_HALF_MAX_DEF = 3;

   localparam int unsigned SIZE_BITS      = 13;
   localparam int unsigned COLOR_BITS     = 24;
   localparam int unsigned PEN_BITS       = 2;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 24;

   localparam logic [SIZE_BITS-1:0]  WIDTH_RESET    = 13'd640;
   localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET   = 13'd480;
   localparam logic [PEN_BITS-1:0]   PEN_HALF_RESET = 2'd1;
   localparam logic [COLOR_BITS-1:0] COLOR_RESET    = 24'd0;

   localparam logic ACTION_BEGIN = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CANVAS_WIDTH    = 3'd0,
      REG_CANVAS_HEIGHT   = 3'd1,
      REG_WRAP_HORIZONTAL = 3'd2,
      REG_WRAP_VERTICAL   = 3'd3,
      REG_PEN_HALF        = 3'd4,
      REG_PEN_COLOR       = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD_WAIT,
      ST_STAMP,
      ST_ADVANCE
   } ctrl_state_type;

   typedef struct packed {
      logic load_seg;
      logic mod_start;
      logic stamp_init;
      logic emit;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic seg_active;
      logic mod_done;
      logic slot_free;
      logic stamp_end;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/plr_channels.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer channels
// Valid/ready interfaces for the request, response and register write beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface plr_req_if #(
   parameter int unsigned COORD_BITS = plr_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface plr_rsp_if #(
   parameter int unsigned COORD_BITS = plr_pkg::COORD_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic signed [COORD_BITS-1:0]      pixel_x;
   logic signed [COORD_BITS-1:0]      pixel_y;
   logic [plr_pkg::COLOR_BITS-1:0]    pixel_color;
   logic                              inside_canvas;
   logic                              stamp_last;
   logic                              segment_done;

   modport source (output valid, pixel_x, pixel_y, pixel_color, inside_canvas, stamp_last,
                   segment_done, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, inside_canvas, stamp_last,
                   segment_done, output ready);
endinterface

interface plr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [plr_pkg::CSR_INDEX_BITS-1:0] index;
   logic [plr_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/plr_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer remainder unit
// Bit-serial restoring remainder of a signed value by an unsigned divisor,
// floored into 0..divisor-1, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_mod_unit #(
   parameter int unsigned VAL_BITS = 14,
   parameter int unsigned DIV_BITS = 13
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [VAL_BITS-1:0] value,
   input  logic [DIV_BITS-1:0]        divisor,   // nonzero, held while busy
   output logic                       done,
   output logic [DIV_BITS-1:0]        result
);

   localparam int unsigned CNT_BITS = $clog2(VAL_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [VAL_BITS-1:0] mag_ff, mag_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic                neg_ff, neg_in;

   logic [DIV_BITS:0]   trial;
   logic [DIV_BITS:0]   trial_sub;
   logic                trial_ge;
   logic [DIV_BITS-1:0] rem_next;

   assign trial     = {rem_ff, mag_ff[VAL_BITS-1]};
   assign trial_ge  = (trial >= {1'b0, divisor});
   assign trial_sub = trial - {1'b0, divisor};
   assign rem_next  = trial_ge ? trial_sub[DIV_BITS-1:0] : trial[DIV_BITS-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VAL_BITS);
         mag_in  = value[VAL_BITS-1] ? VAL_BITS'(-value) : VAL_BITS'(value);
         rem_in  = '0;
         neg_in  = value[VAL_BITS-1];
      end else if (busy_ff) begin
         rem_in = rem_next;
         mag_in = mag_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // negative dividend: fold truncated remainder up into range
   assign done   = done_ff;
   assign result = (neg_ff && (rem_ff != '0)) ? (divisor - rem_ff) : rem_ff;

endmodule

`default_nettype wire

// ===== rtl/plr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer controller
// Sequences one request: segment load, or remainder, stamp walk and advance.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_action,
   output logic                     req_ready,
   output plr_pkg::ctrl_cmd_type    cmd,
   input  plr_pkg::ctrl_status_type status
);
   import plr_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACTION_BEGIN) begin
                  cmd.load_seg = 1'b1;
               end else if (status.seg_active) begin
                  cmd.mod_start = 1'b1;
                  state_in      = ST_MOD_WAIT;
               end
            end
         end
         ST_MOD_WAIT: begin
            if (status.mod_done) begin
               cmd.stamp_init = 1'b1;
               state_in       = ST_STAMP;
            end
         end
         ST_STAMP: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.stamp_end) begin
                  state_in = ST_ADVANCE;
               end
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/plr_datapath.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer datapath
// Registers, segment state, Bresenham update, stamp walkers, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_datapath #(
   parameter int unsigned COORD_BITS   = plr_pkg::COORD_BITS_DEF,
   parameter int unsigned PEN_HALF_MAX = plr_pkg::PEN_HALF_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // register writes
   input  logic                               csr_valid,
   input  logic [plr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [plr_pkg::CSR_DATA_BITS-1:0]  csr_data,
   // request payload
   input  logic signed [COORD_BITS-1:0]       req_start_x,
   input  logic signed [COORD_BITS-1:0]       req_start_y,
   input  logic signed [COORD_BITS-1:0]       req_end_x,
   input  logic signed [COORD_BITS-1:0]       req_end_y,
   // controller link
   input  plr_pkg::ctrl_cmd_type              cmd,
   output plr_pkg::ctrl_status_type           status,
   // response
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [COORD_BITS-1:0]       rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]       rsp_pixel_y,
   output logic [plr_pkg::COLOR_BITS-1:0]     rsp_pixel_color,
   output logic                               rsp_inside_canvas,
   output logic                               rsp_stamp_last,
   output logic                               rsp_segment_done
);
   import plr_pkg::*;

   localparam int unsigned VB       = COORD_BITS + 1;
   localparam int unsigned EB       = COORD_BITS + 2;
   localparam int unsigned PW       = (COORD_BITS > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS + 1;
   localparam int unsigned OFS_BITS = $clog2(2 * PEN_HALF_MAX + 1);

   // ---------------- configuration ----------------
   logic [SIZE_BITS-1:0]  width_ff, width_in;
   logic [SIZE_BITS-1:0]  height_ff, height_in;
   logic                  wrap_h_ff, wrap_h_in;
   logic                  wrap_v_ff, wrap_v_in;
   logic [PEN_BITS-1:0]   pen_half_ff, pen_half_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      wrap_h_in   = wrap_h_ff;
      wrap_v_in   = wrap_v_ff;
      pen_half_in = pen_half_ff;
      color_in    = color_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_CANVAS_WIDTH:    width_in    = csr_data[SIZE_BITS-1:0];
            REG_CANVAS_HEIGHT:   height_in   = csr_data[SIZE_BITS-1:0];
            REG_WRAP_HORIZONTAL: wrap_h_in   = csr_data[0];
            REG_WRAP_VERTICAL:   wrap_v_in   = csr_data[0];
            REG_PEN_HALF:        pen_half_in = csr_data[PEN_BITS-1:0];
            REG_PEN_COLOR:       color_in    = csr_data[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         wrap_h_ff   <= 1'b0;
         wrap_v_ff   <= 1'b0;
         pen_half_ff <= PEN_HALF_RESET;
         color_ff    <= COLOR_RESET;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         wrap_h_ff   <= wrap_h_in;
         wrap_v_ff   <= wrap_v_in;
         pen_half_ff <= pen_half_in;
         color_ff    <= color_in;
      end
   end

   // zero size acts as one
   logic [SIZE_BITS-1:0] w_eff, h_eff;
   assign w_eff = (width_ff == '0)  ? SIZE_BITS'(1) : width_ff;
   assign h_eff = (height_ff == '0) ? SIZE_BITS'(1) : height_ff;

   logic [OFS_BITS-1:0] a_ofs, side_max;
   assign a_ofs    = (pen_half_ff > PEN_HALF_MAX) ? OFS_BITS'(PEN_HALF_MAX)
                                                  : OFS_BITS'(pen_half_ff);
   assign side_max = a_ofs << 1;

   // ---------------- segment state ----------------
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [COORD_BITS-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                         sx_ff, sx_in, sy_ff, sy_in;
   logic signed [EB-1:0]         err_ff, err_in;
   logic                         active_ff, active_in;

   logic signed [VB-1:0] x0_e, y0_e, x1_e, y1_e, dx_diff, dy_diff, dx_abs, dy_abs;
   assign x0_e    = req_start_x;
   assign y0_e    = req_start_y;
   assign x1_e    = req_end_x;
   assign y1_e    = req_end_y;
   assign dx_diff = x1_e - x0_e;
   assign dy_diff = y1_e - y0_e;
   assign dx_abs  = dx_diff[VB-1] ? -dx_diff : dx_diff;
   assign dy_abs  = dy_diff[VB-1] ? -dy_diff : dy_diff;

   // Bresenham decision on doubled error
   logic signed [EB:0] e2, dx_w, dy_w;
   logic               step_x, step_y;
   logic signed [EB-1:0] dx_e, dy_e;
   assign e2     = {err_ff, 1'b0};
   assign dx_w   = signed'((EB + 1)'(dx_ff));
   assign dy_w   = signed'((EB + 1)'(dy_ff));
   assign step_x = (e2 > -dy_w);
   assign step_y = (e2 < dx_w);
   assign dx_e   = signed'(EB'(dx_ff));
   assign dy_e   = signed'(EB'(dy_ff));

   logic seg_done;
   assign seg_done = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      err_in    = err_ff;
      active_in = active_ff;
      if (cmd.load_seg) begin
         cur_x_in  = req_start_x;
         cur_y_in  = req_start_y;
         tgt_x_in  = req_end_x;
         tgt_y_in  = req_end_y;
         dx_in     = dx_abs[COORD_BITS-1:0];
         dy_in     = dy_abs[COORD_BITS-1:0];
         sx_in     = !(req_start_x < req_end_x);
         sy_in     = !(req_start_y < req_end_y);
         err_in    = signed'(EB'(dx_abs[COORD_BITS-1:0]))
                   - signed'(EB'(dy_abs[COORD_BITS-1:0]));
         active_in = 1'b1;
      end else if (cmd.advance) begin
         if (seg_done) begin
            active_in = 1'b0;
         end else begin
            err_in = err_ff - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
            if (step_x) begin
               cur_x_in = sx_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
            end
            if (step_y) begin
               cur_y_in = sy_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         dx_ff     <= '0;
         dy_ff     <= '0;
         sx_ff     <= 1'b0;
         sy_ff     <= 1'b0;
         err_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         err_ff    <= err_in;
         active_ff <= active_in;
      end
   end

   // ---------------- stamp corner and its wrapped position ----------------
   logic signed [VB-1:0] cur_x_e, cur_y_e, base_x, base_y;
   assign cur_x_e = cur_x_ff;
   assign cur_y_e = cur_y_ff;
   assign base_x  = cur_x_e - signed'(VB'(a_ofs));
   assign base_y  = cur_y_e - signed'(VB'(a_ofs));

   logic                 mod_x_done, mod_y_done;
   logic [SIZE_BITS-1:0] mod_x_rem, mod_y_rem;

   plr_mod_unit #(
      .VAL_BITS (VB),
      .DIV_BITS (SIZE_BITS)
   ) u_mod_x (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mod_start),
      .value   (base_x),
      .divisor (w_eff),
      .done    (mod_x_done),
      .result  (mod_x_rem)
   );

   plr_mod_unit #(
      .VAL_BITS (VB),
      .DIV_BITS (SIZE_BITS)
   ) u_mod_y (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mod_start),
      .value   (base_y),
      .divisor (h_eff),
      .done    (mod_y_done),
      .result  (mod_y_rem)
   );

   // ---------------- stamp walkers ----------------
   logic [OFS_BITS-1:0]  ix_ff, ix_in, jy_ff, jy_in;
   logic [SIZE_BITS-1:0] wx_ff, wx_in, wy_ff, wy_in, wy_base_ff, wy_base_in;
   logic [SIZE_BITS-1:0] wx_plus, wy_plus, wx_inc, wy_inc;
   logic                 stamp_end;

   assign wx_plus   = wx_ff + 1'b1;
   assign wy_plus   = wy_ff + 1'b1;
   assign wx_inc    = (wx_plus == w_eff) ? '0 : wx_plus;
   assign wy_inc    = (wy_plus == h_eff) ? '0 : wy_plus;
   assign stamp_end = (ix_ff == side_max) && (jy_ff == side_max);

   always_comb begin
      ix_in      = ix_ff;
      jy_in      = jy_ff;
      wx_in      = wx_ff;
      wy_in      = wy_ff;
      wy_base_in = wy_base_ff;
      if (cmd.stamp_init) begin
         ix_in      = '0;
         jy_in      = '0;
         wx_in      = mod_x_rem;
         wy_in      = mod_y_rem;
         wy_base_in = mod_y_rem;
      end else if (cmd.emit) begin
         if (jy_ff == side_max) begin
            jy_in = '0;
            ix_in = ix_ff + 1'b1;
            wy_in = wy_base_ff;
            wx_in = wx_inc;
         end else begin
            jy_in = jy_ff + 1'b1;
            wy_in = wy_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      ix_ff      <= ix_in;
      jy_ff      <= jy_in;
      wx_ff      <= wx_in;
      wy_ff      <= wy_in;
      wy_base_ff <= wy_base_in;
   end

   // ---------------- pixel position and bounds ----------------
   logic signed [VB-1:0] raw_x, raw_y;
   logic signed [PW-1:0] raw_x_w, raw_y_w, px_w, py_w, w_w, h_w;
   logic                 on_canvas;

   assign raw_x     = base_x + signed'(VB'(ix_ff));
   assign raw_y     = base_y + signed'(VB'(jy_ff));
   assign raw_x_w   = raw_x;
   assign raw_y_w   = raw_y;
   assign px_w      = wrap_h_ff ? signed'(PW'(wx_ff)) : raw_x_w;
   assign py_w      = wrap_v_ff ? signed'(PW'(wy_ff)) : raw_y_w;
   assign w_w       = signed'(PW'(w_eff));
   assign h_w       = signed'(PW'(h_eff));
   assign on_canvas = (px_w >= 0) && (px_w < w_w) && (py_w >= 0) && (py_w < h_w);

   // ---------------- output register ----------------
   logic                         out_valid_ff, out_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic [COLOR_BITS-1:0]        out_color_ff;
   logic                         out_inside_ff, out_last_ff, out_done_ff;
   logic                         slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (cmd.emit) begin
         out_x_ff      <= px_w[COORD_BITS-1:0];
         out_y_ff      <= py_w[COORD_BITS-1:0];
         out_color_ff  <= color_ff;
         out_inside_ff <= on_canvas;
         out_last_ff   <= stamp_end;
         out_done_ff   <= seg_done;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_pixel_color   = out_color_ff;
   assign rsp_inside_canvas = out_inside_ff;
   assign rsp_stamp_last    = out_last_ff;
   assign rsp_segment_done  = out_done_ff;

   assign status.seg_active = active_ff;
   assign status.mod_done   = mod_x_done && mod_y_done;
   assign status.slot_free  = slot_free;
   assign status.stamp_end  = stamp_end;

endmodule

`default_nettype wire

// ===== rtl/pen_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer
// Bresenham line stepper that stamps a square pen, one pixel write per beat.
// ----------------------------------------------------------------------------
// A begin beat (action 0) loads a segment and returns nothing.
// Each step beat (action 1) stamps a (2*pen_half+1)^2 square at the current
// point, columns outer and rows inner, one response beat per pixel, then
// moves the point one pixel toward the end point. The stamp at the end point
// carries segment_done on every pixel; further steps return nothing until
// the next begin. For each step the two bit-serial remainder units first place
// the stamp corner on a wrapped canvas, then the stamp drains at one pixel
// per cycle through the response register while the receiver keeps ready
// high. The response register lets the next request in while the last
// pixel still waits. Register writes are taken in any cycle and must only
// be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pen_line_rasterizer #(
   parameter int unsigned COORD_BITS   = plr_pkg::COORD_BITS_DEF,
   parameter int unsigned PEN_HALF_MAX = plr_pkg::PEN_HALF_MAX_DEF
) (
   input  logic     clock,
   input  logic     reset,
   plr_req_if.sink  req_chan,
   plr_rsp_if.source rsp_chan,
   plr_csr_if.sink  csr_chan
);
   import plr_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;

   // registers never back-pressure
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   // sequencing: load / remainder / stamp walk / advance
   plr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // config, segment state, stamp walkers and the response register
   plr_datapath #(
      .COORD_BITS   (COORD_BITS),
      .PEN_HALF_MAX (PEN_HALF_MAX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_chan.valid),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .req_start_x       (req_chan.start_x),
      .req_start_y       (req_chan.start_y),
      .req_end_x         (req_chan.end_x),
      .req_end_y         (req_chan.end_y),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_pixel_x       (rsp_chan.pixel_x),
      .rsp_pixel_y       (rsp_chan.pixel_y),
      .rsp_pixel_color   (rsp_chan.pixel_color),
      .rsp_inside_canvas (rsp_chan.inside_canvas),
      .rsp_stamp_last    (rsp_chan.stamp_last),
      .rsp_segment_done  (rsp_chan.segment_done)
   );

endmodule

`default_nettype wire

// ===== rtl/plr_checker.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer port checker
// Watches the top-level channels over time; bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pen_line_rasterizer_macros.svh"

module plr_checker #(
   parameter int unsigned COORD_BITS = plr_pkg::COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_pixel_x,
   input logic                  rsp_stamp_last
);

   // stalled response beat stays up and keeps its payload
   `PLR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `PLR_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_pixel_x))

   // mid-stamp pixel pending means the stamp is unfinished: no new request
   `PLR_ASSERT_NOW(a_busy_mid_stamp, rsp_valid && !rsp_stamp_last, !req_ready)

   // reset empties the response register
   `PLR_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

endmodule

bind pen_line_rasterizer plr_checker #(
   .COORD_BITS (COORD_BITS)
) u_plr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pixel_x    (rsp_chan.pixel_x),
   .rsp_stamp_last (rsp_chan.stamp_last)
);

`default_nettype wire

// ===== tb/sv/pen_line_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// Pen line rasterizer testbench
// Drives begin and step beats into the rasterizer, predicts every pen-stamp
// pixel write from a local Bresenham stepper, and checks each response beat
// in order. Directed segments cover the reset setup, the octants, segment
// restart, coordinate and canvas extremes and backpressure. Random phases
// follow, each under its own register setup, some with bursty idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module pen_line_rasterizer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import plr_pkg::*;

   localparam int COORD_W      = COORD_BITS_DEF;
   localparam int PEN_MAX      = PEN_HALF_MAX_DEF;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 5;
   // wait that covers one step: (2*3+1)^2 pixels plus the remainder setup, rounded up
   localparam int STEP_LATENCY = 80;
   localparam int SETTLE_TAIL  = 120;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int BACKLOG_HOLD = 400;
   localparam int PHASE_BEATS  = 44;
   localparam int MAX_REPORTS  = 10;

   // one expected pixel write, laid out like the response channel
   typedef struct packed {
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [COLOR_BITS-1:0] color;
      logic                  on_canvas;
      logic                  last;
      logic                  done;
   } pixel_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plr_req_if #(.COORD_BITS(COORD_W)) req_bus ();
   plr_rsp_if #(.COORD_BITS(COORD_W)) rsp_bus ();
   plr_csr_if                         csr_bus ();

   pen_line_rasterizer #(
      .COORD_BITS   (COORD_W),
      .PEN_HALF_MAX (PEN_MAX)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // pixel writes still owed by the block, oldest first
   pixel_write_type pixel_q[$];

   // register mirror
   logic [SIZE_BITS-1:0]  canvas_w_reg;
   logic [SIZE_BITS-1:0]  canvas_h_reg;
   logic                  wrap_x_reg;
   logic                  wrap_y_reg;
   logic [PEN_BITS-1:0]   pen_reg;
   logic [COLOR_BITS-1:0] color_reg;

   // line stepper state: pen position, end point, distances, error accumulator
   int pos_x, pos_y, goal_x, goal_y, dist_x, dist_y, err_acc;
   bit neg_x, neg_y, seg_live;

   int  beats_counted   = 0;   // begin beats plus steps on a live segment
   int  mismatch_count  = 0;
   int  rsp_hold_cycles = 0;   // long receiver hold-off, counted down below
   bit  idle_on         = 1'b1;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // floor modulo, result always in 0..size-1
   function automatic int wrap_onto(input int v, input int size);
      int r;
      r = v % size;
      if (r < 0) r += size;
      return r;
   endfunction

   // Apply one accepted beat to the local stepper and queue the stamp it owes.
   task automatic predict_beat(input logic act,
                               input logic signed [COORD_W-1:0] sx,
                               input logic signed [COORD_W-1:0] sy,
                               input logic signed [COORD_W-1:0] ex,
                               input logic signed [COORD_W-1:0] ey);
      int w, h, a, px, py, e2;
      bit at_end;
      pixel_write_type pw;
      if (act == ACTION_BEGIN) begin
         // a begin always replaces whatever segment was loaded
         pos_x   = sx;
         pos_y   = sy;
         goal_x  = ex;
         goal_y  = ey;
         dist_x  = (goal_x > pos_x) ? goal_x - pos_x : pos_x - goal_x;
         dist_y  = (goal_y > pos_y) ? goal_y - pos_y : pos_y - goal_y;
         neg_x   = !(pos_x < goal_x);
         neg_y   = !(pos_y < goal_y);
         err_acc = dist_x - dist_y;
         seg_live = 1'b1;
         beats_counted++;
         return;
      end
      if (!seg_live) return;   // step with nothing loaded: no writes
      beats_counted++;

      // a zero-sized axis behaves as size one
      w = (canvas_w_reg == 0) ? 1 : int'(canvas_w_reg);
      h = (canvas_h_reg == 0) ? 1 : int'(canvas_h_reg);
      a = (pen_reg > PEN_MAX) ? PEN_MAX : int'(pen_reg);
      at_end = (pos_x == goal_x) && (pos_y == goal_y);

      // columns outer, rows inner
      for (int i = -a; i <= a; i++) begin
         for (int j = -a; j <= a; j++) begin
            px = pos_x + i;
            py = pos_y + j;
            if (wrap_x_reg) px = wrap_onto(px, w);
            if (wrap_y_reg) py = wrap_onto(py, h);
            pw.x         = px[COORD_W-1:0];
            pw.y         = py[COORD_W-1:0];
            pw.color     = color_reg;
            pw.on_canvas = (px >= 0) && (px < w) && (py >= 0) && (py < h);
            pw.last      = (i == a) && (j == a);
            pw.done      = at_end;
            pixel_q.push_back(pw);
         end
      end

      if (at_end) begin
         seg_live = 1'b0;
      end else begin
         e2 = 2 * err_acc;
         if (e2 > -dist_y) begin
            err_acc -= dist_y;
            pos_x += neg_x ? -1 : 1;
         end
         if (e2 < dist_x) begin
            err_acc += dist_x;
            pos_y += neg_y ? -1 : 1;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: throttle and checker
   // ------------------------------------------------------------------------

   // ready changes on falling edges only; one assignment per edge
   initial begin : rsp_throttle
      int burst;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            while (rsp_hold_cycles > 0) begin
               @(negedge clock);
               rsp_hold_cycles--;
            end
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_bus.ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // every accepted response beat is matched against the oldest pending write
   always @(posedge clock) begin : pixel_check
      pixel_write_type want, got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.x         = rsp_bus.pixel_x;
         got.y         = rsp_bus.pixel_y;
         got.color     = rsp_bus.pixel_color;
         got.on_canvas = rsp_bus.inside_canvas;
         got.last      = rsp_bus.stamp_last;
         got.done      = rsp_bus.segment_done;
         if (pixel_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected pixel beat x=%0d y=%0d color=%06h in=%0b last=%0b done=%0b",
                        $realtime, $signed(got.x), $signed(got.y), got.color, got.on_canvas,
                        got.last, got.done);
         end else begin
            want = pixel_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: pixel mismatch", $realtime);
                  $display("   expected x=%0d y=%0d color=%06h in=%0b last=%0b done=%0b",
                           $signed(want.x), $signed(want.y), want.color, want.on_canvas,
                           want.last, want.done);
                  $display("   actual   x=%0d y=%0d color=%06h in=%0b last=%0b done=%0b",
                           $signed(got.x), $signed(got.y), got.color, got.on_canvas,
                           got.last, got.done);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side helpers; all enter and leave on a falling edge
   // ------------------------------------------------------------------------

   // Offer one beat, hold it until taken, then predict its writes. Valid is
   // left high on exit so back-to-back beats never drop it.
   task automatic send_beat(input logic act, input int sx, input int sy,
                            input int ex, input int ey);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.start_x <= sx[COORD_W-1:0];
      req_bus.start_y <= sy[COORD_W-1:0];
      req_bus.end_x   <= ex[COORD_W-1:0];
      req_bus.end_y   <= ey[COORD_W-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_beat(act, sx[COORD_W-1:0], sy[COORD_W-1:0], ex[COORD_W-1:0], ey[COORD_W-1:0]);
      @(negedge clock);
   endtask

   // step fields are unused by the block, so they carry noise
   task automatic step_pen(input int count);
      repeat (count) send_beat(ACTION_STEP, $urandom, $urandom, $urandom, $urandom);
   endtask

   // begin a segment and step it `extra` times past its end point
   task automatic trace_segment(input int sx, input int sy, input int ex, input int ey,
                                input int extra);
      int adx, ady;
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      send_beat(ACTION_BEGIN, sx, sy, ex, ey);
      step_pen(((adx > ady) ? adx : ady) + 1 + extra);
   endtask

   // Sender pause: drop valid, wait for every owed write, then let a full
   // step's latency pass in case a begin beat is still being absorbed.
   task automatic wait_all_written();
      req_bus.valid <= 1'b0;
      while (pixel_q.size() != 0) @(negedge clock);
      repeat (STEP_LATENCY) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_CANVAS_WIDTH:    canvas_w_reg = value[SIZE_BITS-1:0];
         REG_CANVAS_HEIGHT:   canvas_h_reg = value[SIZE_BITS-1:0];
         REG_WRAP_HORIZONTAL: wrap_x_reg   = value[0];
         REG_WRAP_VERTICAL:   wrap_y_reg   = value[0];
         REG_PEN_HALF:        pen_reg      = value[PEN_BITS-1:0];
         REG_PEN_COLOR:       color_reg    = value[COLOR_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Full register setup once the block has gone quiet. Bits above each
   // field are filled with noise; the block must ignore them.
   task automatic configure(input int w, input int h, input bit wx, input bit wy,
                            input int pen, input int color);
      logic [CSR_DATA_BITS-1:0] junk;
      wait_all_written();
      junk = $urandom;
      write_reg(REG_CANVAS_WIDTH,    (junk & 24'hFFE000) | w[SIZE_BITS-1:0]);
      junk = $urandom;
      write_reg(REG_CANVAS_HEIGHT,   (junk & 24'hFFE000) | h[SIZE_BITS-1:0]);
      junk = $urandom;
      write_reg(REG_WRAP_HORIZONTAL, (junk & 24'hFFFFFE) | wx);
      junk = $urandom;
      write_reg(REG_WRAP_VERTICAL,   (junk & 24'hFFFFFE) | wy);
      junk = $urandom;
      write_reg(REG_PEN_HALF,        (junk & 24'hFFFFFC) | pen[PEN_BITS-1:0]);
      write_reg(REG_PEN_COLOR,       color[COLOR_BITS-1:0]);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Straight out of reset: 640x480, no wrap, pen 1, black. A step with no
   // segment yields nothing; a zero-length segment is done on its first
   // stamp, which hangs off the left and top edges; later steps are silent.
   task automatic test_reset_defaults();
      step_pen(1);
      trace_segment(0, 0, 0, 0, 1);
   endtask

   // Small canvas, single-pixel pen: one shallow and one steep segment in
   // opposite quadrants, so both axes step in both directions.
   task automatic test_octants();
      configure(16, 16, 1'b0, 1'b0, 0, 24'h5A3C96);
      trace_segment(5, 5, 2, 4, 0);
      trace_segment(5, 5, 6, 8, 0);
   endtask

   // begin while a segment is still live drops the old one
   task automatic test_segment_restart();
      send_beat(ACTION_BEGIN, 0, 0, 3, 3);
      step_pen(1);
      trace_segment(10, 1, 10, 0, 0);
   endtask

   // Corner coordinates across the whole field, a zero-width canvas, the
   // largest canvases (wrapped values alias in 13 bits), both pen extremes.
   task automatic test_extremes();
      configure(0, 8191, 1'b1, 1'b1, 3, 24'hFFFFFF);
      send_beat(ACTION_BEGIN, -4096, 4095, 4095, -4096);
      step_pen(2);
      configure(4096, 1, 1'b0, 1'b0, 0, 24'h000000);
      send_beat(ACTION_BEGIN, 4095, -4096, -4096, 4095);
      step_pen(2);
      configure(4096, 4096, 1'b1, 1'b0, 2, 24'hA5F00F);
      trace_segment(4094, 4095, 4095, 4093, 0);
   endtask

   // Receiver holds off long enough for the response register to fill and the
   // request side to stall, then the sender pauses for a full drain.
   task automatic test_backpressure();
      configure(32, 32, 1'b1, 1'b0, 2, 24'h13579B);
      rsp_hold_cycles = BACKLOG_HOLD;
      trace_segment(2, 3, 9, 6, 0);
      wait_all_written();
      trace_segment(4, 4, 4, 1, 1);
   endtask

   // short segments near the canvas or anywhere in the field
   task automatic random_segment();
      int sx, sy, dx, dy, ex, ey, tmp, points;
      if ($urandom_range(0, 1) == 0) begin
         sx = int'($urandom_range(0, 80)) - 8;
         sy = int'($urandom_range(0, 80)) - 8;
      end else begin
         sx = int'($urandom_range(0, 8191)) - 4096;
         sy = int'($urandom_range(0, 8191)) - 4096;
      end
      dx = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      dy = $urandom_range(0, dx);
      if ($urandom_range(0, 1)) begin
         tmp = dx;
         dx  = dy;
         dy  = tmp;
      end
      ex = $urandom_range(0, 1) ? sx + dx : sx - dx;
      ey = $urandom_range(0, 1) ? sy + dy : sy - dy;
      // keep the end point in range by mirroring through the start
      if (ex > 4095 || ex < -4096) ex = 2 * sx - ex;
      if (ey > 4095 || ey < -4096) ey = 2 * sy - ey;
      points = ((dx > dy) ? dx : dy) + 1;
      send_beat(ACTION_BEGIN, sx, sy, ex, ey);
      // now and then cut the segment short; the next begin replaces it
      if ($urandom_range(0, 6) == 0)
         step_pen($urandom_range(0, points - 1));
      else
         step_pen(points + ($urandom_range(0, 3) == 0));
   endtask

   // One random phase under a fresh register setup, extremes included.
   task automatic test_random_phase(input int quota, input bit with_idle);
      int w, h, pen, stop_at;
      idle_on = with_idle;
      case ($urandom_range(0, 4))
         0: w = 0;
         1: w = 1;
         2: w = 4096;
         3: w = 8191;
         default: w = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 4))
         0: h = 0;
         1: h = 1;
         2: h = 4096;
         3: h = 8191;
         default: h = $urandom_range(2, 64);
      endcase
      pen = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : $urandom_range(0, 1);
      configure(w, h, $urandom_range(0, 1), $urandom_range(0, 1), pen,
                $urandom_range(0, 24'hFFFFFF));
      stop_at = beats_counted + quota;
      while (beats_counted < stop_at) begin
         if ($urandom_range(0, 6) == 0)
            send_beat($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
         else
            random_segment();
      end
   endtask

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("pen_line_rasterizer test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      req_bus.valid   = 1'b0;
      req_bus.action  = ACTION_BEGIN;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x   = '0;
      req_bus.end_y   = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = REG_CANVAS_WIDTH;
      csr_bus.data    = '0;

      // mirror and stepper start from the reset state
      canvas_w_reg = WIDTH_RESET;
      canvas_h_reg = HEIGHT_RESET;
      wrap_x_reg   = 1'b0;
      wrap_y_reg   = 1'b0;
      pen_reg      = PEN_HALF_RESET;
      color_reg    = COLOR_RESET;
      pos_x = 0; pos_y = 0; goal_x = 0; goal_y = 0;
      dist_x = 0; dist_y = 0; err_acc = 0;
      neg_x = 1'b0; neg_y = 1'b0; seg_live = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_octants();
      test_segment_restart();
      test_extremes();
      test_backpressure();

      // random phases; idling is off in the middle phase and in the last one
      test_random_phase(PHASE_BEATS, 1'b1);
      test_random_phase(PHASE_BEATS, 1'b1);
      test_random_phase(PHASE_BEATS, 1'b0);
      test_random_phase(PHASE_BEATS, 1'b1);
      test_random_phase(PHASE_BEATS, 1'b0);

      wait_all_written();
      repeat (SETTLE_TAIL) @(negedge clock);

      if (mismatch_count == 0 && pixel_q.size() == 0) begin
         $display("pen_line_rasterizer test passed");
      end else begin
         $display("pen_line_rasterizer test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
